// ===== hdl/jse_pkg.sv =====
// Shared types, codes and byte-generation functions for the JSON string escaper.
// No dependencies; imported by jse_front, jse_queue, jse_back and json_string_escape.
package jse_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] CP_PLANE = 21'h010000;

  // Escape kinds, decided by the front end
  localparam logic [2:0] K_FLAG  = 3'd0;  // bad input, flagged result, one 00 byte
  localparam logic [2:0] K_PAIR  = 3'd1;  // backslash + one char
  localparam logic [2:0] K_RAW   = 3'd2;  // one raw byte
  localparam logic [2:0] K_UTF2  = 3'd3;
  localparam logic [2:0] K_UTF3  = 3'd4;
  localparam logic [2:0] K_UTF4  = 3'd5;
  localparam logic [2:0] K_UESC  = 3'd6;  // \uXXXX
  localparam logic [2:0] K_USURR = 3'd7;  // \uXXXX\uXXXX surrogate pair

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] C_BS  = 8'h08;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_LF  = 8'h0A;
  localparam logic [7:0] C_FF  = 8'h0C;
  localparam logic [7:0] C_CR  = 8'h0D;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] data;  // code point, escape char, or offset above the BMP
  } jse_desc_t;

  function automatic logic [7:0] jse_hex(logic [3:0] nib);
    logic [7:0] b;
    if (nib < 4'd10) b = CH_ZERO + {4'b0, nib};
    else b = CH_A + {4'b0, nib} - 8'd10;
    return b;
  endfunction

  function automatic logic [3:0] jse_count(logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      K_FLAG:  n = 4'd1;
      K_PAIR:  n = 4'd2;
      K_RAW:   n = 4'd1;
      K_UTF2:  n = 4'd2;
      K_UTF3:  n = 4'd3;
      K_UTF4:  n = 4'd4;
      K_UESC:  n = 4'd6;
      default: n = 4'd12;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] jse_byte(jse_desc_t d, logic [3:0] idx);
    logic [15:0] unit;
    logic [3:0]  pos;
    logic [7:0]  b;
    unit = d.data[15:0];
    pos  = idx;
    if (d.kind == K_USURR) begin
      if (idx < 4'd6) begin
        unit = {6'b110110, d.data[19:10]};
      end else begin
        unit = {6'b110111, d.data[9:0]};
        pos  = idx - 4'd6;
      end
    end
    case (d.kind)
      K_FLAG: b = 8'h00;
      K_PAIR: b = (idx == 4'd0) ? CH_BSLASH : d.data[7:0];
      K_RAW:  b = d.data[7:0];
      K_UTF2: b = (idx == 4'd0) ? {3'b110, d.data[10:6]} : {2'b10, d.data[5:0]};
      K_UTF3: begin
        case (idx)
          4'd0:    b = {4'b1110, d.data[15:12]};
          4'd1:    b = {2'b10, d.data[11:6]};
          default: b = {2'b10, d.data[5:0]};
        endcase
      end
      K_UTF4: begin
        case (idx)
          4'd0:    b = {5'b11110, d.data[20:18]};
          4'd1:    b = {2'b10, d.data[17:12]};
          4'd2:    b = {2'b10, d.data[11:6]};
          default: b = {2'b10, d.data[5:0]};
        endcase
      end
      default: begin
        case (pos)
          4'd0:    b = CH_BSLASH;
          4'd1:    b = CH_U;
          4'd2:    b = jse_hex(unit[15:12]);
          4'd3:    b = jse_hex(unit[11:8]);
          4'd4:    b = jse_hex(unit[7:4]);
          default: b = jse_hex(unit[3:0]);
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/jse_front.sv =====
// Front end: classifies one code point into an escape descriptor.
// Depends on jse_pkg.
module jse_front (
  input  logic               mode,
  input  logic [20:0]        code_point,
  output jse_pkg::jse_desc_t desc
);
  import jse_pkg::*;

  logic        is_surr;
  logic [20:0] plane_off;

  assign is_surr   = (code_point[20:11] == 10'h01B);
  assign plane_off = code_point - CP_PLANE;

  always_comb begin
    desc.kind = K_RAW;
    desc.data = code_point;
    if (code_point > CP_MAX || (mode && is_surr)) begin
      desc.kind = K_FLAG;
    end else begin
      case (code_point)
        {13'b0, CH_QUOTE}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_QUOTE};
        end
        {13'b0, CH_BSLASH}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_BSLASH};
        end
        {13'b0, C_BS}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_B};
        end
        {13'b0, C_FF}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_F};
        end
        {13'b0, C_TAB}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_T};
        end
        {13'b0, C_CR}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_R};
        end
        {13'b0, C_LF}: begin
          desc.kind = K_PAIR;
          desc.data = {13'b0, CH_N};
        end
        default: begin
          if (code_point < 21'h20) desc.kind = K_UESC;
          else if (code_point < 21'h80) desc.kind = K_RAW;
          else if (!mode) begin
            if (code_point < 21'h800) desc.kind = K_UTF2;
            else if (code_point < CP_PLANE) desc.kind = K_UTF3;
            else desc.kind = K_UTF4;
          end else if (code_point < CP_PLANE) begin
            desc.kind = K_UESC;
          end else begin
            desc.kind = K_USURR;
            desc.data = plane_off;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/jse_queue.sv =====
// Small descriptor FIFO between the front end and the byte sequencer.
// Depends on jse_pkg.
module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  jse_pkg::jse_desc_t wr_desc,
  input  logic               rd_en,
  output jse_pkg::jse_desc_t head,
  output logic               nonempty,
  output logic               full
);
  import jse_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_desc_t        store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;

  assign nonempty = (cnt != '0);
  assign full     = (cnt == CW'(DEPTH));
  assign head     = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) cnt <= cnt + 1'b1;
      else if (rd_en && !wr_en) cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== hdl/jse_back.sv =====
// Back end: walks the head descriptor one byte per unstalled cycle into the output register.
// Depends on jse_pkg.
module jse_back (
  input  logic               clk,
  input  logic               rst,
  input  jse_pkg::jse_desc_t head,
  input  logic               head_valid,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_pop,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  output logic               bad_char
);
  import jse_pkg::*;

  logic [3:0] idx;
  logic       out_free;
  logic       take;
  logic       is_last;

  assign out_free = !out_valid || out_pop;
  assign take     = head_valid && out_free;
  assign is_last  = (idx == jse_count(head.kind) - 4'd1);
  assign head_pop = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 4'd0 : idx + 4'd1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte  <= jse_byte(head, idx);
      last_byte <= is_last;
      bad_char  <= (head.kind == K_FLAG);
    end
  end

endmodule

// ===== hdl/json_string_escape.sv =====
// Top level of the JSON string escaper: front end, descriptor queue, byte sequencer.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
// Takes one code point per push and delivers its JSON-escaped text one byte per pop,
// with last_byte on the final byte of each code point. Code points are accepted one per
// cycle while the descriptor queue (QDEPTH entries) has room; bytes leave at one per
// cycle while pop is asserted. A code point gives 1 output byte for plain characters,
// 2 to 4 for short escapes and UTF-8, 6 for \uXXXX and 12 for a surrogate pair.
// The byte sequencer's single output register sets the byte rate. Write
// encoding_mode only while no transfer is in flight.
module json_string_escape #(
  parameter int QDEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [20:0] code_point,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        bad_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import jse_pkg::*;

  logic      encoding_mode;
  jse_desc_t front_desc;
  jse_desc_t head;
  logic      head_valid;
  logic      head_pop;
  logic      out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) encoding_mode <= 1'b0;
    else if (cfg_valid && cfg_ready) encoding_mode <= cfg_data;
  end

  jse_front u_front (
    .mode       (encoding_mode),
    .code_point (code_point),
    .desc       (front_desc)
  );

  jse_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push && !full),
    .wr_desc  (front_desc),
    .rd_en    (head_pop),
    .head     (head),
    .nonempty (head_valid),
    .full     (full)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .bad_char   (bad_char)
  );

endmodule

// ===== hdl/jse_checker.sv =====
// Port-level checks for json_string_escape, attached by bind.
// Depends on json_string_escape's ports only.
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       last_byte,
  input logic       bad_char
);

  // a flagged result is always the only one for its code point
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && bad_char |-> last_byte)
    else $error("bad_char without last_byte");

  a_bad_no_byte: assert property (@(posedge clk) disable iff (rst)
    !empty && bad_char |-> out_byte == 8'h00)
    else $error("bad_char with nonzero byte");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queue state not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_byte))
    else $error("stalled result changed");

endmodule

bind json_string_escape jse_checker u_jse_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .last_byte (last_byte),
  .bad_char  (bad_char)
);
